// ===== src/bgsc_pkg.sv =====
// Package for the button gesture screen cycler: field widths, reset values,
// result event codes and configuration register indexes.
// Used by the channel interfaces and the top level; depends on nothing.
package bgsc_pkg;

  // Field and register widths.
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned TAP_W    = 10;
  localparam int unsigned DIM_W    = 14;
  localparam int unsigned HOLD_W   = 16;
  localparam int unsigned LEVEL_W  = 7;
  localparam int unsigned SCREEN_W = 3;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  // Register reset values.
  localparam logic [TAP_W-1:0]   TAP_MIN_RST      = TAP_W'(30);
  localparam logic [DIM_W-1:0]   DIM_MIN_RST      = DIM_W'(700);
  localparam logic [HOLD_W-1:0]  REFRESH_HOLD_RST = HOLD_W'(2500);
  localparam logic [LEVEL_W-1:0] BL_THRESHOLD_RST = LEVEL_W'(40);
  localparam logic [LEVEL_W-1:0] BL_DIM_RST       = LEVEL_W'(15);
  localparam logic [LEVEL_W-1:0] BL_BRIGHT_RST    = LEVEL_W'(100);

  // State reset values.
  localparam logic [LEVEL_W-1:0]  BACKLIGHT_RST = LEVEL_W'(100);
  localparam logic [SCREEN_W-1:0] SCREEN_RST    = '0;

  // Event reported with each result.
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_NEXT    = 2'd1,
    EV_LIGHT   = 2'd2,
    EV_REFRESH = 2'd3
  } event_e;

  // Configuration register indexes (byte address divided by four).
  typedef enum logic [2:0] {
    REG_TAP_MIN      = 3'd0,
    REG_DIM_MIN      = 3'd1,
    REG_REFRESH_HOLD = 3'd2,
    REG_BL_THRESHOLD = 3'd3,
    REG_BL_DIM       = 3'd4,
    REG_BL_BRIGHT    = 3'd5
  } reg_idx_e;

endpackage

// ===== src/bgsc_if.sv =====
// Valid/ready channel interfaces for button samples and their results.
// Depends on bgsc_pkg for widths and the event type.
interface bgsc_item_if;
  logic                              valid;
  logic                              ready;
  logic                              pressed;
  logic [bgsc_pkg::TIME_W-1:0]       now_ms;
  logic                              anim_available;

  modport source (output valid, pressed, now_ms, anim_available, input ready);
  modport sink   (input valid, pressed, now_ms, anim_available, output ready);
endinterface

interface bgsc_result_if;
  logic                              valid;
  logic                              ready;
  bgsc_pkg::event_e                  event_res;
  logic [bgsc_pkg::SCREEN_W-1:0]     screen;
  logic [bgsc_pkg::LEVEL_W-1:0]      backlight;

  modport source (output valid, event_res, screen, backlight, input ready);
  modport sink   (input valid, event_res, screen, backlight, output ready);
endinterface

// ===== src/button_gesture_screen_cycler_top.sv =====
// Top level of the button gesture screen cycler: sample channel, result channel
// and APB register port. Depends on bgsc_pkg and the interfaces in bgsc_if.sv.
//
// Each request carries one button sample and yields exactly one result. The
// block takes one request per clock cycle while results are taken. An
// accepted request moves into the input register; its result is loaded into
// the result register once that register is free and shows on the result
// channel from there. The press state (edge, start time, hold mark, screen and
// backlight) is updated when the result register is loaded, so back to back
// samples see each other's effect. A result that is not taken holds the
// result register, and the input register still takes one more request before
// ready drops.
// Registers should be written only while no request is in flight.
module button_gesture_screen_cycler_top #(
  parameter int unsigned SCREEN_COUNT = 5
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  bgsc_item_if.sink                        item_i,
  bgsc_result_if.source                    result_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bgsc_pkg::ADDR_W-1:0]      paddr,
  input  logic [bgsc_pkg::DATA_W-1:0]      pwdata,
  output logic [bgsc_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);

  localparam int unsigned SW = bgsc_pkg::SCREEN_W;
  localparam int unsigned LW = bgsc_pkg::LEVEL_W;

  // Configuration registers.
  logic [bgsc_pkg::TAP_W-1:0]  tap_min_q;
  logic [bgsc_pkg::DIM_W-1:0]  dim_min_q;
  logic [bgsc_pkg::HOLD_W-1:0] refresh_hold_q;
  logic [LW-1:0]               bl_threshold_q;
  logic [LW-1:0]               bl_dim_q;
  logic [LW-1:0]               bl_bright_q;

  bgsc_pkg::reg_idx_e reg_idx;
  logic               cfg_write;

  // Input register.
  logic                        s1_valid_q;
  logic                        s1_pressed_q;
  logic [bgsc_pkg::TIME_W-1:0] s1_now_q;
  logic                        s1_anim_q;

  // Press state.
  logic                        was_pressed_q, was_pressed_d;
  logic [bgsc_pkg::TIME_W-1:0] press_start_q, press_start_d;
  logic                        hold_done_q, hold_done_d;
  logic [SW-1:0]               screen_q, screen_d;
  logic [LW-1:0]               backlight_q, backlight_d;

  // Result register.
  logic                        res_valid_q;
  bgsc_pkg::event_e            res_event_q, event_d;
  logic [SW-1:0]               res_screen_q;
  logic [LW-1:0]               res_backlight_q;

  logic                        res_load;
  logic                        s1_fire;
  logic                        in_take;
  logic [bgsc_pkg::TIME_W-1:0] held;
  logic [SW:0]                 screen_inc;
  logic [SW-1:0]               screen_adv;

  // APB: always ready, register picked by the word address.
  assign pready    = 1'b1;
  assign reg_idx   = bgsc_pkg::reg_idx_e'(paddr[bgsc_pkg::ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_min_q      <= bgsc_pkg::TAP_MIN_RST;
      dim_min_q      <= bgsc_pkg::DIM_MIN_RST;
      refresh_hold_q <= bgsc_pkg::REFRESH_HOLD_RST;
      bl_threshold_q <= bgsc_pkg::BL_THRESHOLD_RST;
      bl_dim_q       <= bgsc_pkg::BL_DIM_RST;
      bl_bright_q    <= bgsc_pkg::BL_BRIGHT_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        bgsc_pkg::REG_TAP_MIN:      tap_min_q      <= pwdata[bgsc_pkg::TAP_W-1:0];
        bgsc_pkg::REG_DIM_MIN:      dim_min_q      <= pwdata[bgsc_pkg::DIM_W-1:0];
        bgsc_pkg::REG_REFRESH_HOLD: refresh_hold_q <= pwdata[bgsc_pkg::HOLD_W-1:0];
        bgsc_pkg::REG_BL_THRESHOLD: bl_threshold_q <= pwdata[LW-1:0];
        bgsc_pkg::REG_BL_DIM:       bl_dim_q       <= pwdata[LW-1:0];
        bgsc_pkg::REG_BL_BRIGHT:    bl_bright_q    <= pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back, zero extended.
  always_comb begin
    unique case (reg_idx)
      bgsc_pkg::REG_TAP_MIN:      prdata = bgsc_pkg::DATA_W'(tap_min_q);
      bgsc_pkg::REG_DIM_MIN:      prdata = bgsc_pkg::DATA_W'(dim_min_q);
      bgsc_pkg::REG_REFRESH_HOLD: prdata = bgsc_pkg::DATA_W'(refresh_hold_q);
      bgsc_pkg::REG_BL_THRESHOLD: prdata = bgsc_pkg::DATA_W'(bl_threshold_q);
      bgsc_pkg::REG_BL_DIM:       prdata = bgsc_pkg::DATA_W'(bl_dim_q);
      bgsc_pkg::REG_BL_BRIGHT:    prdata = bgsc_pkg::DATA_W'(bl_bright_q);
      default:                    prdata = '0;
    endcase
  end

  // Handshake: the input register moves on whenever the result register frees up.
  assign res_load     = !res_valid_q || result_o.ready;
  assign s1_fire      = s1_valid_q && res_load;
  assign item_i.ready = !s1_valid_q || s1_fire;
  assign in_take      = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_pressed_q <= item_i.pressed;
      s1_now_q     <= item_i.now_ms;
      s1_anim_q    <= item_i.anim_available;
    end
  end

  // Next screen index: wrap at the end and skip the last screen without animation.
  always_comb begin
    screen_inc = {1'b0, screen_q} + (SW+1)'(1);
    if (screen_inc >= (SW+1)'(SCREEN_COUNT)) begin
      screen_inc = '0;
    end
    if (screen_inc == (SW+1)'(SCREEN_COUNT - 1) && !s1_anim_q) begin
      screen_inc = '0;
    end
    screen_adv = screen_inc[SW-1:0];
  end

  // Press time is taken modulo the timer wrap.
  assign held = s1_now_q - press_start_q;

  // Gesture decision for the sample in the input register.
  always_comb begin
    was_pressed_d = s1_pressed_q;
    press_start_d = press_start_q;
    hold_done_d   = hold_done_q;
    screen_d      = screen_q;
    backlight_d   = backlight_q;
    event_d       = bgsc_pkg::EV_NONE;
    priority if (s1_pressed_q && !was_pressed_q) begin
      press_start_d = s1_now_q;
      hold_done_d   = 1'b0;
    end else if (s1_pressed_q && !hold_done_q &&
                 held > bgsc_pkg::TIME_W'(refresh_hold_q)) begin
      hold_done_d = 1'b1;
      event_d     = bgsc_pkg::EV_REFRESH;
    end else if (!s1_pressed_q && was_pressed_q && !hold_done_q) begin
      if (held > bgsc_pkg::TIME_W'(dim_min_q)) begin
        backlight_d = (backlight_q > bl_threshold_q) ? bl_dim_q : bl_bright_q;
        event_d     = bgsc_pkg::EV_LIGHT;
      end else if (held > bgsc_pkg::TIME_W'(tap_min_q)) begin
        screen_d = screen_adv;
        event_d  = bgsc_pkg::EV_NEXT;
      end
    end else begin
      // Steady level or release after a handled hold: nothing happens.
    end
  end

  // Press state advances once per sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_pressed_q <= 1'b0;
      press_start_q <= '0;
      hold_done_q   <= 1'b0;
      screen_q      <= bgsc_pkg::SCREEN_RST;
      backlight_q   <= bgsc_pkg::BACKLIGHT_RST;
    end else if (s1_fire) begin
      was_pressed_q <= was_pressed_d;
      press_start_q <= press_start_d;
      hold_done_q   <= hold_done_d;
      screen_q      <= screen_d;
      backlight_q   <= backlight_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (s1_fire) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_event_q     <= event_d;
      res_screen_q    <= screen_d;
      res_backlight_q <= backlight_d;
    end
  end

  assign result_o.valid     = res_valid_q;
  assign result_o.event_res = res_event_q;
  assign result_o.screen    = res_screen_q;
  assign result_o.backlight = res_backlight_q;

`ifndef SYNTHESIS
  // The screen index never leaves the configured range.
  a_screen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, screen_q} < (SW+1)'(SCREEN_COUNT))
    else $error("screen index out of range");

  // A refresh result always leaves the hold marked as handled.
  a_refresh_marks_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && event_d == bgsc_pkg::EV_REFRESH) |=> hold_done_q)
    else $error("refresh fired without marking the hold");

  // The backlight only changes with a backlight event.
  a_backlight_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && event_d != bgsc_pkg::EV_LIGHT) |=> $stable(backlight_q))
    else $error("backlight changed without a backlight event");

  // Input stalls only when both registers are full and the result is held.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_i.ready |-> (s1_valid_q && res_valid_q && !result_o.ready))
    else $error("input stalled without a full pipeline");
`endif

endmodule
